// ===== hw/rtl/lzfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzfd_pkg
// shared types and constants of the lz77 factor decoder
// ----------------------------------------------------------------------------
package lzfd_pkg;

    // history depth, a power of two so that position mod depth is a bit slice
    localparam int WINDOW    = 4096;
    localparam int MAX_COPY  = 64;
    localparam int HIST_AW   = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(MAX_COPY + 1);
    localparam int POS_W     = 32;
    localparam int LEN_W     = 16;
    localparam int BYTE_W    = 8;

    localparam logic [POS_W-1:0] WINDOW_POS   = POS_W'(WINDOW);
    localparam logic [LEN_W-1:0] MAX_COPY_LEN = LEN_W'(MAX_COPY);

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SOURCE = 2'd1,
        ERR_LENGTH = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_DONE,
        S_CHK_SRC,
        S_CHK_WIN,
        S_CHK_DIST,
        S_CLIP,
        S_READ,
        S_EMIT,
        S_ERR
    } t_state;

    // operands of the shared subtract and compare unit
    typedef struct packed {
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [POS_W-1:0] diff;
        logic             borrow;
        logic             zero;
    } t_alu_res;

    typedef struct packed {
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [BYTE_W-1:0]  wr_data;
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
    } t_hist_ctl;

endpackage

// ===== hw/rtl/lzfd_alu.sv =====
// ----------------------------------------------------------------------------
// lzfd_alu
// shared 32-bit subtractor with borrow and zero flags
// ----------------------------------------------------------------------------
module lzfd_alu import lzfd_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [POS_W:0] w_diff;

    // a - b, borrow set when a < b
    assign w_diff       = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_res.diff   = w_diff[POS_W-1:0];
    assign o_res.borrow = w_diff[POS_W];
    assign o_res.zero   = (w_diff[POS_W-1:0] == '0);

endmodule

// ===== hw/rtl/lzfd_history.sv =====
// ----------------------------------------------------------------------------
// lzfd_history
// history window memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lzfd_history import lzfd_pkg::*; (
    input  logic              i_clk,
    input  t_hist_ctl         i_ctl,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [WINDOW];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/lz77_factor_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lz77_factor_decoder_unit
// lz77 factor decoder with absolute copy sources and a history window
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                    payload
// --------  ---  ---------------------------  ---------------------------------
// s_axis    in   s_axis_tvalid/s_axis_tready  factor: source_or_literal, length
// m_axis    out  m_axis_tvalid/m_axis_tready  one decoded byte or error result
// cfg       in   i_cfg_valid/o_cfg_ready      total_length
//
// one factor at a time; input is ready only while the sequencer is idle
// checks run over the shared subtractor, one compare per cycle, in order:
//   total - wp, src - wp, wp - src, window - dist, rem - len
// each copied byte passes a memory read state and then a write/emit state
// a full output register stalls the emit cycle until m_axis_tready
// i_rst_n (synchronous) clears the position, total length and control state;
// the history memory is not cleared, only produced positions are ever read
//
module lz77_factor_decoder_unit import lzfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // factor input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] source_or_literal, [47:32] copy_length
    // decoded output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] out_position
    output logic        m_axis_tlast,   // last_of_run
    output logic [2:0]  m_axis_tuser,   // [0] stream_done, [2:1] error_code
    // total length register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    t_state r_state, n_state;

    // factor and stream state
    logic [POS_W-1:0]   r_src;
    logic [LEN_W-1:0]   r_len;
    logic [POS_W-1:0]   r_wp;
    logic [POS_W-1:0]   r_total;
    logic [POS_W-1:0]   r_rem;      // total_length - write position
    logic [POS_W-1:0]   r_dist;     // write position - source
    logic [HIST_AW-1:0] r_rd_addr;
    logic [CNT_W-1:0]   r_left;     // bytes still to emit for this factor
    logic               r_lit;
    t_err               r_err;

    // output register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;
    logic               r_out_done;
    t_err               r_out_err;

    t_alu_req           w_alu_req;
    t_alu_res           w_alu_res;
    t_hist_ctl          w_hist;
    logic [BYTE_W-1:0]  w_rd_data;
    logic               w_out_free;
    logic               w_emit;     // byte transaction loaded into output register
    logic               w_err_load; // error transaction loaded into output register
    logic               w_in_acc;
    logic               w_cfg_acc;
    logic [BYTE_W-1:0]  w_byte;

    lzfd_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    lzfd_history u_hist (
        .i_clk     (i_clk),
        .i_ctl     (w_hist),
        .o_rd_data (w_rd_data)
    );

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_byte     = r_lit ? r_src[BYTE_W-1:0] : w_rd_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_CHK_DONE;
            end
            S_CHK_DONE: begin
                // total - wp: stream finished when wp >= total
                if (w_alu_res.borrow || w_alu_res.zero) begin
                    n_state = S_IDLE;
                end else if (r_len == '0) begin
                    n_state = S_EMIT;
                end else if (r_len > MAX_COPY_LEN) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_CHK_SRC;
                end
            end
            S_CHK_SRC: begin
                // src - wp: not yet produced when src >= wp
                n_state = w_alu_res.borrow ? S_CHK_WIN : S_ERR;
            end
            S_CHK_WIN: begin
                n_state = S_CHK_DIST;
            end
            S_CHK_DIST: begin
                // window - dist: out of window when dist > window
                n_state = w_alu_res.borrow ? S_ERR : S_CLIP;
            end
            S_CLIP: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_left == CNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            S_ERR: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready  = 1'b0;
        o_cfg_ready    = 1'b0;
        w_alu_req.a    = r_total;
        w_alu_req.b    = r_wp;
        w_hist.wr_en   = 1'b0;
        w_hist.wr_addr = r_wp[HIST_AW-1:0];
        w_hist.wr_data = w_byte;
        w_hist.rd_en   = 1'b0;
        w_hist.rd_addr = r_rd_addr;
        w_emit         = 1'b0;
        w_err_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                o_cfg_ready   = 1'b1;
            end
            S_CHK_DONE: begin
                w_alu_req.a = r_total;
                w_alu_req.b = r_wp;
            end
            S_CHK_SRC: begin
                w_alu_req.a = r_src;
                w_alu_req.b = r_wp;
            end
            S_CHK_WIN: begin
                w_alu_req.a = r_wp;
                w_alu_req.b = r_src;
            end
            S_CHK_DIST: begin
                w_alu_req.a = WINDOW_POS;
                w_alu_req.b = r_dist;
            end
            S_CLIP: begin
                w_alu_req.a = r_rem;
                w_alu_req.b = {{(POS_W-LEN_W){1'b0}}, r_len};
            end
            S_READ: begin
                w_hist.rd_en = 1'b1;
            end
            S_EMIT: begin
                w_emit       = w_out_free;
                w_hist.wr_en = w_out_free;
            end
            S_ERR: begin
                w_err_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // stream control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_total <= '0;
        end else begin
            if (w_cfg_acc) r_total <= i_cfg_data;
            if (w_emit)    r_wp    <= r_wp + POS_W'(1);
        end
    end

    // factor datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_src <= s_axis_tdata[31:0];
            r_len <= s_axis_tdata[47:32];
        end
        case (r_state)
            S_CHK_DONE: begin
                r_rem  <= w_alu_res.diff;
                r_lit  <= (r_len == '0);
                r_left <= CNT_W'(1);
                r_err  <= ERR_LENGTH;
            end
            S_CHK_SRC: begin
                r_err <= ERR_SOURCE;
            end
            S_CHK_WIN: begin
                r_dist <= w_alu_res.diff;
            end
            S_CLIP: begin
                // copy is cut off at total_length
                r_left    <= w_alu_res.borrow ? r_rem[CNT_W-1:0] : r_len[CNT_W-1:0];
                r_rd_addr <= r_src[HIST_AW-1:0];
            end
            S_EMIT: begin
                if (w_emit) begin
                    r_rd_addr <= r_rd_addr + HIST_AW'(1);
                    r_rem     <= r_rem - POS_W'(1);
                    r_left    <= r_left - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // output register, parts the decoder from the downstream side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit || w_err_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_pos  <= r_wp;
            r_out_last <= (r_left == CNT_W'(1));
            r_out_done <= (r_rem == POS_W'(1));
            r_out_err  <= ERR_NONE;
        end else if (w_err_load) begin
            r_out_byte <= '0;
            r_out_pos  <= r_wp;
            r_out_last <= 1'b1;
            r_out_done <= 1'b0;
            r_out_err  <= r_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pos, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_err, r_out_done};

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives lz77 factors into lz77_factor_decoder_unit under random gaps and
// back-pressure, decodes them in a behavioral copy of the decoder and checks
// every output byte, error result, run marker and done flag in order
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lzfd_pkg::*;

    localparam int SETTLE_CYCLES = 150;   // trailing work after the last byte
    localparam int STALL_LIMIT   = 3000;  // cycles with no transaction at all
    localparam int CHUNK_ITEMS   = 120;   // decoded factors per random phase

    // one expected or observed output transaction
    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] pos;
        logic        last;
        logic        done;
        t_err        err;
    } decoded_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // [31:0] source_or_literal, [47:32] copy_length
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [7:0] out_byte, [39:8] out_position
    logic        m_axis_tlast;         // last_of_run
    logic [2:0]  m_axis_tuser;         // [0] stream_done, [2:1] error_code
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data    = '0;

    // decoder copy: history, write position and the total length register
    logic [7:0]  hist [WINDOW];
    logic [31:0] wr_pos    = '0;
    logic [31:0] total_len = '0;
    decoded_t    pending_bytes [$];

    decoded_t got_byte;
    decoded_t want_byte;
    int       fail_count  = 0;
    int       idle_cycles = 0;
    int       stall_left  = 0;
    bit       idling      = 1'b1;   // random gaps on both sides when set

    lz77_factor_decoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 2);
        end else if (r < 90) begin
            return $urandom_range(3, 8);
        end else if (r < 98) begin
            return $urandom_range(9, 20);
        end
        return $urandom_range(25, 40);
    endfunction

    // decode one accepted factor and queue the bytes it produces
    function automatic void decode_factor(input logic [31:0] src, input logic [15:0] len);
        logic [31:0] n;
        logic [31:0] rd;
        logic [7:0]  b;
        // stream already complete, factor dropped
        if (wr_pos >= total_len) begin
            return;
        end
        if (len == '0) begin
            hist[wr_pos[HIST_AW-1:0]] = src[7:0];
            pending_bytes.push_back('{data: src[7:0], pos: wr_pos, last: 1'b1,
                                      done: (wr_pos + 1 == total_len), err: ERR_NONE});
            wr_pos++;
        end else if (len > MAX_COPY_LEN) begin
            // length is checked ahead of the source
            pending_bytes.push_back('{data: '0, pos: wr_pos, last: 1'b1, done: 1'b0,
                                      err: ERR_LENGTH});
        end else if (src >= wr_pos || wr_pos - src > WINDOW_POS) begin
            pending_bytes.push_back('{data: '0, pos: wr_pos, last: 1'b1, done: 1'b0,
                                      err: ERR_SOURCE});
        end else begin
            n = 32'(len);
            if (n > total_len - wr_pos) begin
                n = total_len - wr_pos;
            end
            // byte by byte, so an overlapping copy sees its own output
            for (int i = 0; i < int'(n); i++) begin
                rd = src + 32'(i);
                b  = hist[rd[HIST_AW-1:0]];
                hist[wr_pos[HIST_AW-1:0]] = b;
                pending_bytes.push_back('{data: b, pos: wr_pos, last: (i + 1 == int'(n)),
                                          done: (wr_pos + 1 == total_len), err: ERR_NONE});
                wr_pos++;
            end
        end
    endfunction

    // mostly well-formed factors against the current position, some noise
    function automatic void random_factor(output logic [31:0] src, output logic [15:0] len);
        int          r;
        int          pick;
        logic [31:0] lo;
        r = $urandom_range(0, 99);
        if (r < 20 || wr_pos == '0) begin
            src = $urandom;
            len = '0;
        end else if (r < 80) begin
            lo = (wr_pos > WINDOW_POS) ? wr_pos - WINDOW_POS : '0;
            if ($urandom_range(0, 1) == 1) begin
                src = wr_pos - $urandom_range(1, (wr_pos < 16) ? wr_pos : 16);
            end else begin
                src = $urandom_range(wr_pos - 1, lo);
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len = 16'($urandom_range(1, 16));
            end else if (pick < 9) begin
                len = 16'($urandom_range(17, MAX_COPY - 1));
            end else begin
                len = MAX_COPY_LEN;
            end
        end else begin
            case ($urandom_range(0, 4))
                0: begin
                    src = $urandom;
                    len = 16'($urandom);
                end
                1: begin
                    // source not produced yet
                    src = wr_pos + $urandom_range(0, 100);
                    len = 16'($urandom_range(1, MAX_COPY));
                end
                2: begin
                    // source fell out of the window
                    src = (wr_pos > WINDOW_POS + 100) ?
                          wr_pos - WINDOW_POS - 1 - $urandom_range(0, 99) : $urandom;
                    len = 16'($urandom_range(1, MAX_COPY));
                end
                3: begin
                    src = wr_pos - 1;
                    len = 16'(MAX_COPY + 1 + $urandom_range(0, 15));
                end
                default: begin
                    src = $urandom;
                    len = 16'($urandom_range(1, MAX_COPY));
                end
            endcase
        end
    endfunction

    // one factor transaction on the input stream
    task automatic send_factor(input logic [31:0] src, input logic [15:0] len);
        int gap;
        gap = (idling && $urandom_range(0, 99) < 40) ? gap_length() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {len, src};
        do @(posedge i_clk); while (!s_axis_tready);
        decode_factor(src, len);
    endtask

    task automatic write_total_length(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        total_len = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop sending, let every queued byte drain, then let the block settle
    task automatic wait_all_decoded();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // total length 0: nothing may come out
    task automatic test_ignored_after_reset();
        send_factor(32'h0000_0041, 16'd0);
        send_factor(32'h0000_0000, 16'd5);
        wait_all_decoded();
        write_total_length(32'h0000_0000);
        send_factor(32'hFFFF_FFFF, 16'hFFFF);
        wait_all_decoded();
    endtask

    task automatic test_basic_factors();
        write_total_length(32'hFFFF_FFFF);
        send_factor(32'h0000_0000, 16'd1);          // nothing produced yet
        send_factor(32'h0000_0000, 16'd0);          // literal 00
        send_factor(32'hFFFF_FFFF, 16'd0);          // literal ff, upper bits unused
        send_factor(32'h1234_5680, 16'd0);
        send_factor(32'h0000_0000, 16'd1);
        send_factor(wr_pos - 1, MAX_COPY_LEN);      // overlap repeats one byte
        send_factor(32'h0000_0000, 16'd3);
        send_factor(wr_pos, 16'd4);                 // source equal to position
        send_factor(32'hFFFF_FFFF, 16'd1);
        send_factor(32'h0000_0000, MAX_COPY_LEN + 16'd1);
        send_factor(32'hFFFF_FFFF, 16'hFFFF);       // length error wins over source
        send_factor(wr_pos - 3, 16'd10);
        wait_all_decoded();
    endtask

    // copies cut at the total length, done flag, factors after the end
    task automatic test_run_clipping();
        write_total_length(wr_pos + 32'd5);
        send_factor(32'h0000_0000, 16'd20);
        send_factor(32'h0000_0055, 16'd0);
        send_factor(32'h0000_0000, MAX_COPY_LEN + 16'd1);
        wait_all_decoded();
        write_total_length(wr_pos + 32'd1);
        send_factor(32'h0000_00A5, 16'd0);
        wait_all_decoded();
        write_total_length(wr_pos + 32'd3);
        send_factor(32'h0000_005A, 16'd0);
        send_factor(wr_pos - 1, 16'd2);
        wait_all_decoded();
    endtask

    task automatic test_random_stream();
        logic [31:0] src;
        logic [15:0] len;
        int          decoded;
        for (int chunk = 0; chunk < 4; chunk++) begin
            wait_all_decoded();
            idling = (chunk != 1);
            // third phase ends the stream partway through
            write_total_length((chunk == 2) ? wr_pos + 32'd600 : 32'hFFFF_FFFF);
            decoded = 0;
            while (decoded < CHUNK_ITEMS && wr_pos < total_len) begin
                random_factor(src, len);
                send_factor(src, len);
                decoded++;
            end
            if (chunk == 2) begin
                repeat (3) begin
                    random_factor(src, len);
                    send_factor(src, len);
                end
            end
        end
        wait_all_decoded();
        idling = 1'b1;
    endtask

    // sources exactly at and just beyond the window distance
    task automatic test_window_edge();
        while (wr_pos <= WINDOW_POS) begin
            send_factor(wr_pos - 1, MAX_COPY_LEN);
        end
        send_factor(wr_pos - WINDOW_POS, MAX_COPY_LEN);
        send_factor(wr_pos - WINDOW_POS - 1, 16'd1);
        send_factor(wr_pos - WINDOW_POS + 1, 16'd2);
        wait_all_decoded();
    endtask

    // output back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            m_axis_tready = 1'b1;
            if (idling && $urandom_range(0, 99) < 25) begin
                stall_left = gap_length();
            end
        end
    end

    // compare each output transaction with the oldest queued byte
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_byte = '{data: m_axis_tdata[7:0], pos: m_axis_tdata[39:8],
                         last: m_axis_tlast, done: m_axis_tuser[0],
                         err: t_err'(m_axis_tuser[2:1])};
            if (pending_bytes.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected output byte %h pos %0d last %b done %b err %0d",
                         $time, got_byte.data, got_byte.pos, got_byte.last,
                         got_byte.done, got_byte.err);
            end else begin
                want_byte = pending_bytes.pop_front();
                if (got_byte !== want_byte) begin
                    fail_count++;
                    $display({"%0t: expected byte %h pos %0d last %b done %b err %0d, ",
                              "got byte %h pos %0d last %b done %b err %0d"},
                             $time, want_byte.data, want_byte.pos, want_byte.last,
                             want_byte.done, want_byte.err, got_byte.data, got_byte.pos,
                             got_byte.last, got_byte.done, got_byte.err);
                end
            end
        end
    end

    // hang detection: any transaction on any channel resets the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("lz77_factor_decoder_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_ignored_after_reset();
        test_basic_factors();
        test_run_clipping();
        test_random_stream();
        test_window_edge();
        if (fail_count == 0) begin
            $display("lz77_factor_decoder_unit test passed");
        end else begin
            $display("lz77_factor_decoder_unit test failed");
        end
        $finish;
    end

endmodule
